// ===== sv/lam_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lam_pkg
// Shared types, widths and the multiply-accumulate program of the look-at
// view matrix unit.
// ---------------------------------------------------------------------------
package lam_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int VEC_W      = 64;
    localparam int MAG_W      = VEC_W;
    localparam int SCL_W      = 30;
    localparam int SQ_W       = 2 * SCL_W;
    localparam int ROOT_W     = 63;
    localparam int ROOT_STEPS = 32;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int LEN_W      = 31;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int REM_W      = LEN_W + QUO_W;
    localparam int UNIT_W     = FRAC_BITS + 2;
    localparam int OPA_W      = FRAC_BITS + 3;
    localparam int PROD_W     = OPA_W + DATA_W;
    localparam int ACC_W      = 64;
    localparam int OP_W       = 5;
    localparam int ROW_W      = 2;
    localparam int ADDR_W     = 4;
    localparam int REG_SEL_W  = 2;

    localparam logic [OP_W-1:0] OP_CROSS_FIRST = OP_W'(0);
    localparam logic [OP_W-1:0] OP_CROSS_END   = OP_W'(5);
    localparam logic [OP_W-1:0] OP_ROW_FIRST   = OP_W'(6);
    localparam logic [OP_W-1:0] OP_LAST        = OP_W'(20);

    localparam logic [ROW_W-1:0] ROW_RIGHT = ROW_W'(0);
    localparam logic [ROW_W-1:0] ROW_UP    = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_FWD   = ROW_W'(2);

    localparam logic [REG_SEL_W-1:0] REG_UP_X = REG_SEL_W'(0);
    localparam logic [REG_SEL_W-1:0] REG_UP_Y = REG_SEL_W'(1);
    localparam logic [REG_SEL_W-1:0] REG_UP_Z = REG_SEL_W'(2);

    typedef enum logic [3:0] {
        A_F0, A_F1, A_F2, A_R0, A_R1, A_R2, A_U0, A_U1, A_U2
    } opa_sel_t;

    typedef enum logic [3:0] {
        B_UP0, B_UP1, B_UP2, B_F0, B_F1, B_F2, B_E0, B_E1, B_E2
    } opb_sel_t;

    typedef enum logic [3:0] {
        D_NONE, D_C0, D_C1, D_C2, D_U0, D_U1, D_U2, D_T0, D_T1, D_T2
    } dst_t;

    typedef struct packed {
        opa_sel_t a;
        opb_sel_t b;
        logic     sub;
        logic     first;
        dst_t     dst;
    } mac_op_t;

    typedef enum logic [2:0] {
        CS_IDLE, CS_NORM_F, CS_START_R, CS_NORM_R, CS_MUL, CS_ACC, CS_EMIT
    } core_state_t;

    typedef enum logic [2:0] {
        NS_IDLE, NS_SCALE, NS_SQUARE, NS_ROOT, NS_DIVIDE
    } norm_state_t;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] eye;
        logic [2:0][DIFF_W-1:0] diff;
    } q_entry_t;

    typedef struct packed {
        logic                  start;
        logic [2:0][VEC_W-1:0] vec;
    } norm_req_t;

    typedef struct packed {
        logic                   done;
        logic                   zero;
        logic [2:0][UNIT_W-1:0] unit;
    } norm_rsp_t;

    function automatic mac_op_t mac_op(input logic [OP_W-1:0] idx);
        mac_op_t op;
        op = '{A_F0, B_UP0, 1'b0, 1'b1, D_NONE};
        unique case (idx)
            OP_W'(0):  op = '{A_F1, B_UP2, 1'b0, 1'b1, D_NONE};
            OP_W'(1):  op = '{A_F2, B_UP1, 1'b1, 1'b0, D_C0};
            OP_W'(2):  op = '{A_F2, B_UP0, 1'b0, 1'b1, D_NONE};
            OP_W'(3):  op = '{A_F0, B_UP2, 1'b1, 1'b0, D_C1};
            OP_W'(4):  op = '{A_F0, B_UP1, 1'b0, 1'b1, D_NONE};
            OP_W'(5):  op = '{A_F1, B_UP0, 1'b1, 1'b0, D_C2};
            OP_W'(6):  op = '{A_R1, B_F2,  1'b0, 1'b1, D_NONE};
            OP_W'(7):  op = '{A_R2, B_F1,  1'b1, 1'b0, D_U0};
            OP_W'(8):  op = '{A_R2, B_F0,  1'b0, 1'b1, D_NONE};
            OP_W'(9):  op = '{A_R0, B_F2,  1'b1, 1'b0, D_U1};
            OP_W'(10): op = '{A_R0, B_F1,  1'b0, 1'b1, D_NONE};
            OP_W'(11): op = '{A_R1, B_F0,  1'b1, 1'b0, D_U2};
            OP_W'(12): op = '{A_R0, B_E0,  1'b1, 1'b1, D_NONE};
            OP_W'(13): op = '{A_R1, B_E1,  1'b1, 1'b0, D_NONE};
            OP_W'(14): op = '{A_R2, B_E2,  1'b1, 1'b0, D_T0};
            OP_W'(15): op = '{A_U0, B_E0,  1'b1, 1'b1, D_NONE};
            OP_W'(16): op = '{A_U1, B_E1,  1'b1, 1'b0, D_NONE};
            OP_W'(17): op = '{A_U2, B_E2,  1'b1, 1'b0, D_T1};
            OP_W'(18): op = '{A_F0, B_E0,  1'b0, 1'b1, D_NONE};
            OP_W'(19): op = '{A_F1, B_E1,  1'b0, 1'b0, D_NONE};
            OP_W'(20): op = '{A_F2, B_E2,  1'b0, 1'b0, D_T2};
            default:   op = '{A_F0, B_UP0, 1'b0, 1'b1, D_NONE};
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lam_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lam_front
// Accept poses, form aim minus eye and queue them for the back end.
// ---------------------------------------------------------------------------
module lam_front import lam_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [6*DATA_W-1:0]  s_tdata,
    input  wire logic                 q_pop,
    output logic                      q_valid,
    output q_entry_t                  q_data
);

    q_entry_t    ent_reg [2];
    q_entry_t    ent_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ent_next.eye[i]  = s_tdata[i*DATA_W +: DATA_W];
            ent_next.diff[i] = DIFF_W'($signed(s_tdata[(i+3)*DATA_W +: DATA_W]))
                             - DIFF_W'($signed(s_tdata[i*DATA_W +: DATA_W]));
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= ent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule
`default_nettype wire

// ===== sv/lam_norm.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lam_norm
// Vector normalizer: scale, sum of squares, bit-serial square root and
// three-lane restoring division.
// ---------------------------------------------------------------------------
module lam_norm import lam_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire norm_req_t  req,
    output norm_rsp_t       rsp
);

    localparam logic [MAG_W-1:0] HI_COARSE = MAG_W'(1) << (SCL_W + 8);
    localparam logic [MAG_W-1:0] HI_FINE   = MAG_W'(1) << SCL_W;
    localparam logic [MAG_W-1:0] LO_COARSE = MAG_W'(1) << (SCL_W - 9);
    localparam logic [MAG_W-1:0] LO_FINE   = MAG_W'(1) << (SCL_W - 1);

    norm_state_t              state_reg, state_next;
    logic [MAG_W-1:0]         mag_reg [3];
    logic [MAG_W-1:0]         mx_reg;
    logic [2:0]               neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [ROOT_W-1:0]        sum_reg;
    logic [ROOT_W-1:0]        n_reg;
    logic [ROOT_W-1:0]        res_reg;
    logic [ROOT_W-1:0]        bit_reg;
    logic [REM_W-1:0]         rem_reg [3];
    logic [REM_W-1:0]         dv_reg;
    logic [QUO_W-1:0]         quo_reg [3];
    logic                     done_reg;
    logic                     zero_reg;
    logic [2:0][UNIT_W-1:0]   unit_reg;

    logic [MAG_W-1:0]         mag_in [3];
    logic [MAG_W-1:0]         mx_in;
    logic [SCL_W-1:0]         sq_op;
    logic [ROOT_W-1:0]        sum_fin;
    logic [ROOT_W-1:0]        trial;
    logic                     root_ge;
    logic [ROOT_W-1:0]        n_nx;
    logic [ROOT_W-1:0]        res_nx;
    logic [LEN_W-1:0]         len;
    logic [REM_W-1:0]         num [3];
    logic                     div_ge [3];
    logic [REM_W-1:0]         rem_nx [3];
    logic [QUO_W-1:0]         quo_nx [3];
    logic                     root_last;
    logic                     div_last;

    assign rsp.done = done_reg;
    assign rsp.zero = zero_reg;
    assign rsp.unit = unit_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = req.vec[i][VEC_W-1] ? (~req.vec[i] + MAG_W'(1)) : req.vec[i];
        end
        mx_in = mag_in[0];
        if (mag_in[1] > mx_in) begin
            mx_in = mag_in[1];
        end
        if (mag_in[2] > mx_in) begin
            mx_in = mag_in[2];
        end

        unique case (cnt_reg)
            CNT_W'(1): sq_op = mag_reg[1][SCL_W-1:0];
            CNT_W'(2): sq_op = mag_reg[2][SCL_W-1:0];
            default:   sq_op = mag_reg[0][SCL_W-1:0];
        endcase
        sum_fin = sum_reg + ROOT_W'(sq_reg);

        trial   = res_reg + bit_reg;
        root_ge = (n_reg >= trial);
        n_nx    = root_ge ? (n_reg - trial) : n_reg;
        res_nx  = root_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        len     = res_nx[LEN_W-1:0];

        for (int i = 0; i < 3; i++) begin
            num[i]    = (REM_W'(mag_reg[i][SCL_W-1:0]) << FRAC_BITS) + REM_W'(len >> 1);
            div_ge[i] = (rem_reg[i] >= dv_reg);
            rem_nx[i] = div_ge[i] ? (rem_reg[i] - dv_reg) : rem_reg[i];
            quo_nx[i] = {quo_reg[i][QUO_W-2:0], div_ge[i]};
        end

        root_last = (cnt_reg == CNT_W'(ROOT_STEPS - 1));
        div_last  = (cnt_reg == CNT_W'(QUO_W - 1));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            NS_IDLE: begin
                if (req.start) begin
                    state_next = NS_SCALE;
                end
            end
            NS_SCALE: begin
                if (mx_reg == '0) begin
                    state_next = NS_IDLE;
                end else if (mx_reg < HI_FINE && mx_reg >= LO_FINE) begin
                    state_next = NS_SQUARE;
                end
            end
            NS_SQUARE: begin
                if (cnt_reg == CNT_W'(3)) begin
                    state_next = NS_ROOT;
                end
            end
            NS_ROOT: begin
                if (root_last) begin
                    state_next = NS_DIVIDE;
                end
            end
            NS_DIVIDE: begin
                if (div_last) begin
                    state_next = NS_IDLE;
                end
            end
            default: state_next = NS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == NS_SCALE && mx_reg == '0)
                      || (state_reg == NS_DIVIDE && div_last);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            NS_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= mag_in[i];
                    neg_reg[i] <= req.vec[i][VEC_W-1];
                end
                mx_reg <= mx_in;
            end
            NS_SCALE: begin
                priority if (mx_reg == '0) begin
                    zero_reg <= 1'b1;
                    unit_reg <= '0;
                end else if (mx_reg >= HI_COARSE) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 8;
                    mx_reg <= mx_reg >> 8;
                end else if (mx_reg >= HI_FINE) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    mx_reg <= mx_reg >> 1;
                end else if (mx_reg < LO_COARSE) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 8;
                    mx_reg <= mx_reg << 8;
                end else if (mx_reg < LO_FINE) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    mx_reg <= mx_reg << 1;
                end else begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end
            end
            NS_SQUARE: begin
                sq_reg  <= sq_op * sq_op;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg != '0) begin
                    sum_reg <= sum_fin;
                end
                if (cnt_reg == CNT_W'(3)) begin
                    n_reg   <= sum_fin;
                    res_reg <= '0;
                    bit_reg <= ROOT_W'(1) << (ROOT_W - 1);
                    cnt_reg <= '0;
                end
            end
            NS_ROOT: begin
                n_reg   <= n_nx;
                res_reg <= res_nx;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (root_last) begin
                    for (int i = 0; i < 3; i++) begin
                        rem_reg[i] <= num[i];
                        quo_reg[i] <= '0;
                    end
                    dv_reg  <= REM_W'(len) << (QUO_W - 1);
                    cnt_reg <= '0;
                end
            end
            NS_DIVIDE: begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[i] <= rem_nx[i];
                    quo_reg[i] <= quo_nx[i];
                end
                dv_reg  <= dv_reg >> 1;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (div_last) begin
                    zero_reg <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        unit_reg[i] <= neg_reg[i] ? (UNIT_W'(0) - UNIT_W'(quo_nx[i]))
                                                  : UNIT_W'(quo_nx[i]);
                    end
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/lam_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lam_core
// Back end: sequence the two normalizations and the multiply-accumulate
// program, then emit the three matrix rows through an output register.
// ---------------------------------------------------------------------------
module lam_core import lam_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire q_entry_t             q_data,
    input  wire logic [DATA_W-1:0]    up_x,
    input  wire logic [DATA_W-1:0]    up_y,
    input  wire logic [DATA_W-1:0]    up_z,
    output norm_req_t                 nreq,
    input  wire norm_rsp_t            nrsp,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [4*DATA_W-1:0]       m_tdata,
    output logic [ROW_W:0]            m_tuser,
    output logic                      m_tlast
);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = -(ACC_W'(64'sd2147483648));

    core_state_t                 state_reg, state_next;
    logic [OP_W-1:0]             op_reg;
    logic [ROW_W-1:0]            row_reg;
    logic                        deg_reg;
    logic [DATA_W-1:0]           eye_reg [3];
    logic signed [UNIT_W-1:0]    f_reg [3];
    logic signed [UNIT_W-1:0]    r_reg [3];
    logic signed [OPA_W-1:0]     u_reg [3];
    logic signed [DATA_W-1:0]    t_reg [3];
    logic signed [VEC_W-1:0]     c_reg [3];
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        m_valid_reg;
    logic [4*DATA_W-1:0]         m_data_reg;
    logic [ROW_W:0]              m_user_reg;
    logic                        m_last_reg;

    mac_op_t                     op;
    logic signed [OPA_W-1:0]     opa;
    logic signed [DATA_W-1:0]    opb;
    logic signed [ACC_W-1:0]     acc_base;
    logic signed [ACC_W-1:0]     acc_nx;
    logic signed [ACC_W-1:0]     rnd;
    logic signed [DATA_W-1:0]    sat;
    logic                        out_free;
    logic [DATA_W-1:0]           col [4];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        op = mac_op(op_reg);
        unique case (op.a)
            A_F0:    opa = OPA_W'(f_reg[0]);
            A_F1:    opa = OPA_W'(f_reg[1]);
            A_F2:    opa = OPA_W'(f_reg[2]);
            A_R0:    opa = OPA_W'(r_reg[0]);
            A_R1:    opa = OPA_W'(r_reg[1]);
            A_R2:    opa = OPA_W'(r_reg[2]);
            A_U0:    opa = u_reg[0];
            A_U1:    opa = u_reg[1];
            A_U2:    opa = u_reg[2];
            default: opa = '0;
        endcase
        unique case (op.b)
            B_UP0:   opb = $signed(up_x);
            B_UP1:   opb = $signed(up_y);
            B_UP2:   opb = $signed(up_z);
            B_F0:    opb = DATA_W'(f_reg[0]);
            B_F1:    opb = DATA_W'(f_reg[1]);
            B_F2:    opb = DATA_W'(f_reg[2]);
            B_E0:    opb = $signed(eye_reg[0]);
            B_E1:    opb = $signed(eye_reg[1]);
            B_E2:    opb = $signed(eye_reg[2]);
            default: opb = '0;
        endcase
        acc_base = op.first ? '0 : acc_reg;
        acc_nx   = op.sub ? (acc_base - ACC_W'(prod_reg)) : (acc_base + ACC_W'(prod_reg));
        rnd      = (acc_nx + RND_HALF) >>> FRAC_BITS;
        priority if (rnd > SAT_MAX) begin
            sat = SAT_MAX[DATA_W-1:0];
        end else if (rnd < SAT_MIN) begin
            sat = SAT_MIN[DATA_W-1:0];
        end else begin
            sat = rnd[DATA_W-1:0];
        end

        unique case (row_reg)
            ROW_RIGHT: begin
                col[0] = DATA_W'(r_reg[0]);
                col[1] = DATA_W'(r_reg[1]);
                col[2] = DATA_W'(r_reg[2]);
                col[3] = t_reg[0];
            end
            ROW_UP: begin
                col[0] = DATA_W'(u_reg[0]);
                col[1] = DATA_W'(u_reg[1]);
                col[2] = DATA_W'(u_reg[2]);
                col[3] = t_reg[1];
            end
            default: begin
                col[0] = DATA_W'(0) - DATA_W'(f_reg[0]);
                col[1] = DATA_W'(0) - DATA_W'(f_reg[1]);
                col[2] = DATA_W'(0) - DATA_W'(f_reg[2]);
                col[3] = t_reg[2];
            end
        endcase
        if (deg_reg) begin
            for (int i = 0; i < 4; i++) col[i] = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        nreq.start = 1'b0;
        for (int i = 0; i < 3; i++) begin
            nreq.vec[i] = VEC_W'($signed(q_data.diff[i]));
        end
        unique case (state_reg)
            CS_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    nreq.start = 1'b1;
                    state_next = CS_NORM_F;
                end
            end
            CS_NORM_F: begin
                if (nrsp.done) begin
                    state_next = nrsp.zero ? CS_EMIT : CS_MUL;
                end
            end
            CS_START_R: begin
                nreq.start = 1'b1;
                for (int i = 0; i < 3; i++) nreq.vec[i] = c_reg[i];
                state_next = CS_NORM_R;
            end
            CS_NORM_R: begin
                if (nrsp.done) begin
                    state_next = nrsp.zero ? CS_EMIT : CS_MUL;
                end
            end
            CS_MUL: begin
                state_next = CS_ACC;
            end
            CS_ACC: begin
                priority if (op_reg == OP_CROSS_END) begin
                    state_next = CS_START_R;
                end else if (op_reg == OP_LAST) begin
                    state_next = CS_EMIT;
                end else begin
                    state_next = CS_MUL;
                end
            end
            CS_EMIT: begin
                if (out_free && row_reg == ROW_FWD) begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == CS_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            CS_IDLE: begin
                for (int i = 0; i < 3; i++) eye_reg[i] <= q_data.eye[i];
                deg_reg <= 1'b0;
                row_reg <= ROW_RIGHT;
            end
            CS_NORM_F: begin
                if (nrsp.done) begin
                    deg_reg <= nrsp.zero;
                    for (int i = 0; i < 3; i++) f_reg[i] <= $signed(nrsp.unit[i]);
                    op_reg <= OP_CROSS_FIRST;
                end
            end
            CS_NORM_R: begin
                if (nrsp.done) begin
                    deg_reg <= nrsp.zero;
                    for (int i = 0; i < 3; i++) r_reg[i] <= $signed(nrsp.unit[i]);
                    op_reg <= OP_ROW_FIRST;
                end
            end
            CS_MUL: begin
                prod_reg <= opa * opb;
            end
            CS_ACC: begin
                acc_reg <= acc_nx;
                op_reg  <= op_reg + OP_W'(1);
                unique case (op.dst)
                    D_C0:    c_reg[0] <= acc_nx;
                    D_C1:    c_reg[1] <= acc_nx;
                    D_C2:    c_reg[2] <= acc_nx;
                    D_U0:    u_reg[0] <= rnd[OPA_W-1:0];
                    D_U1:    u_reg[1] <= rnd[OPA_W-1:0];
                    D_U2:    u_reg[2] <= rnd[OPA_W-1:0];
                    D_T0:    t_reg[0] <= sat;
                    D_T1:    t_reg[1] <= sat;
                    D_T2:    t_reg[2] <= sat;
                    default: ;
                endcase
            end
            CS_EMIT: begin
                if (out_free) begin
                    m_data_reg <= {col[3], col[2], col[1], col[0]};
                    m_user_reg <= {deg_reg, row_reg};
                    m_last_reg <= (row_reg == ROW_FWD);
                    row_reg    <= row_reg + ROW_W'(1);
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/look_at_view_matrix_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// look_at_view_matrix_unit
// Right-handed look-at view matrix: three rows per camera pose.
// Each of the two normalizations runs 1 to 11 scaling steps, 4 squares,
// 32 root steps and 17 divide steps; the 21 multiply-accumulate steps each
// pass a multiply state and then an accumulate state. Aim equal to eye, or a
// zero right vector, goes straight to emitting degenerate all-zero rows.
// Rows leave one per cycle while m_tready stays high; the core works on one
// pose at a time and the front queue holds two poses.
// Reset: synchronous, active low; clears control state, up = (0, 1.0, 0).
// ---------------------------------------------------------------------------
module look_at_view_matrix_unit import lam_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [6*DATA_W-1:0]   s_tdata,  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [4*DATA_W-1:0]        m_tdata,  // col0, col1, col2, col3
    output logic [ROW_W:0]             m_tuser,  // row_index[1:0], degenerate
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [DATA_W-1:0]       up_x_reg, up_y_reg, up_z_reg;
    logic [REG_SEL_W-1:0]    reg_sel;
    logic                    cfg_wr;
    logic                    q_valid;
    logic                    q_pop;
    q_entry_t                q_data;
    norm_req_t               nreq;
    norm_rsp_t               nrsp;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_UP_X: prdata = up_x_reg;
            REG_UP_Y: prdata = up_y_reg;
            REG_UP_Z: prdata = up_z_reg;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_x_reg <= '0;
            up_y_reg <= DATA_W'(1) << FRAC_BITS;
            up_z_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_UP_X: up_x_reg <= pwdata;
                REG_UP_Y: up_y_reg <= pwdata;
                REG_UP_Z: up_z_reg <= pwdata;
                default:  ;
            endcase
        end
    end

    lam_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    lam_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nreq),
        .rsp     (nrsp)
    );

    lam_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .up_x     (up_x_reg),
        .up_y     (up_y_reg),
        .up_z     (up_z_reg),
        .nreq     (nreq),
        .nrsp     (nrsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
